// File: rtl/adfd_pkg.sv
// ----------------------------------------------------------------------------
// adfd_pkg
// Shared types and constants of the DRAM address field decoder.
// ----------------------------------------------------------------------------
package adfd_pkg;

	localparam int FIELD_BITS     = 32;
	localparam int BANK_BITS      = 8;
	localparam int CODE_BITS      = 3;
	localparam int ORDER_BITS     = 24;
	localparam int COUNT_BITS     = 4;
	localparam int WIDTH_BITS     = 5;
	localparam int CFG_DATA_BITS  = 24;
	localparam int CFG_INDEX_BITS = 3;
	localparam int IN_ADDR_BITS   = 32;
	localparam int IN_RID_BITS    = 8;
	localparam int IN_TDATA_BITS  = 40;
	localparam int OUT_TDATA_BITS = 136;

	// field codes held in each slot of the layout
	localparam logic [CODE_BITS-1:0] FLD_RANK       = 3'd0;
	localparam logic [CODE_BITS-1:0] FLD_BANK_GROUP = 3'd1;
	localparam logic [CODE_BITS-1:0] FLD_BANK       = 3'd2;
	localparam logic [CODE_BITS-1:0] FLD_SUBARRAY   = 3'd3;
	localparam logic [CODE_BITS-1:0] FLD_ROW        = 3'd4;
	localparam logic [CODE_BITS-1:0] FLD_COLUMN     = 3'd5;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_SLOT_ORDER       = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SLOT_COUNT       = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANK_WIDTH       = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BANK_GROUP_WIDTH = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BANK_WIDTH       = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SUBARRAY_WIDTH   = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_WIDTH        = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_WIDTH     = 3'd7;

	typedef struct packed {
		logic [ORDER_BITS-1:0] slot_order;
		logic [COUNT_BITS-1:0] slot_count;
		logic [WIDTH_BITS-1:0] rank_width;
		logic [WIDTH_BITS-1:0] bank_group_width;
		logic [WIDTH_BITS-1:0] bank_width;
		logic [WIDTH_BITS-1:0] subarray_width;
		logic [WIDTH_BITS-1:0] row_width;
		logic [WIDTH_BITS-1:0] column_width;
	} adfd_cfg_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] column;
		logic [FIELD_BITS-1:0] row;
		logic [FIELD_BITS-1:0] subarray;
		logic [BANK_BITS-1:0]  bank;
		logic [FIELD_BITS-1:0] bank_group;
	} adfd_fields_t;

endpackage

// File: rtl/adfd_regs.sv
// ----------------------------------------------------------------------------
// adfd_regs
// Layout registers, written through a plain write port.
// ----------------------------------------------------------------------------
module adfd_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [adfd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [adfd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output adfd_pkg::adfd_cfg_t                  cfg
);
	import adfd_pkg::*;

	adfd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOT_ORDER:       cfg_q.slot_order       <= cfg_data[ORDER_BITS-1:0];
				REG_SLOT_COUNT:       cfg_q.slot_count       <= cfg_data[COUNT_BITS-1:0];
				REG_RANK_WIDTH:       cfg_q.rank_width       <= cfg_data[WIDTH_BITS-1:0];
				REG_BANK_GROUP_WIDTH: cfg_q.bank_group_width <= cfg_data[WIDTH_BITS-1:0];
				REG_BANK_WIDTH:       cfg_q.bank_width       <= cfg_data[WIDTH_BITS-1:0];
				REG_SUBARRAY_WIDTH:   cfg_q.subarray_width   <= cfg_data[WIDTH_BITS-1:0];
				REG_ROW_WIDTH:        cfg_q.row_width        <= cfg_data[WIDTH_BITS-1:0];
				REG_COLUMN_WIDTH:     cfg_q.column_width     <= cfg_data[WIDTH_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/adfd_cell.sv
// ----------------------------------------------------------------------------
// adfd_cell
// One slot of the layout: peels its field off the low end of the remaining
// address and hands the rest to the next cell.
// ----------------------------------------------------------------------------
module adfd_cell #(
	parameter int ADDR_BITS = 32,
	parameter int SLOT      = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  adfd_pkg::adfd_cfg_t     cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [ADDR_BITS-1:0]    in_rest,
	input  adfd_pkg::adfd_fields_t  in_fields,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ADDR_BITS-1:0]    out_rest,
	output adfd_pkg::adfd_fields_t  out_fields
);
	import adfd_pkg::*;

	logic [CODE_BITS-1:0]  code;
	logic [WIDTH_BITS-1:0] w;
	logic                  code_ok;
	logic                  take;
	logic [FIELD_BITS-1:0] low;
	logic [FIELD_BITS-1:0] field_val;
	logic [ADDR_BITS-1:0]  next_rest;
	adfd_fields_t          next_fields;

	logic                  valid_q;
	logic [ADDR_BITS-1:0]  rest_q;
	adfd_fields_t          fields_q;

	assign code = cfg.slot_order[CODE_BITS*SLOT +: CODE_BITS];

	always_comb begin
		w       = '0;
		code_ok = 1'b1;
		case (code)
			FLD_RANK:       w = cfg.rank_width;
			FLD_BANK_GROUP: w = cfg.bank_group_width;
			FLD_BANK:       w = cfg.bank_width;
			FLD_SUBARRAY:   w = cfg.subarray_width;
			FLD_ROW:        w = cfg.row_width;
			FLD_COLUMN:     w = cfg.column_width;
			default:        code_ok = 1'b0;
		endcase
	end

	// slot in use and naming a real field
	assign take = (cfg.slot_count > COUNT_BITS'(SLOT)) && code_ok;

	generate
		if (ADDR_BITS >= FIELD_BITS) begin : g_low_cut
			assign low = in_rest[FIELD_BITS-1:0];
		end else begin : g_low_ext
			assign low = {{(FIELD_BITS-ADDR_BITS){1'b0}}, in_rest};
		end
	endgenerate

	assign field_val = low & ~({FIELD_BITS{1'b1}} << w);
	assign next_rest = take ? (in_rest >> w) : in_rest;

	always_comb begin
		next_fields = in_fields;
		if (take) begin
			case (code)
				FLD_BANK_GROUP: next_fields.bank_group = field_val;
				FLD_SUBARRAY:   next_fields.subarray   = field_val;
				FLD_ROW:        next_fields.row        = field_val;
				FLD_COLUMN:     next_fields.column     = field_val;
				default: begin
					// rank and bank consume bits but are not reported
				end
			endcase
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rest_q   <= next_rest;
			fields_q <= next_fields;
		end
	end

	assign out_valid  = valid_q;
	assign out_rest   = rest_q;
	assign out_fields = fields_q;

endmodule

// File: rtl/dram_address_field_decoder_core.sv
// ----------------------------------------------------------------------------
// dram_address_field_decoder_core
// Splits a physical address into bank group, subarray, row and column under
// a programmable slot layout; bank is the requestor ID.
// ----------------------------------------------------------------------------
// Usage: one transaction is accepted per clock and one result leaves per
// clock while the output is not stalled; each transaction passes through
// all SLOTS cell registers on its way from input to output. The decode runs
// through a row of SLOTS cells, one per layout slot; the first cell serves
// the last slot, so the address is peeled from its low end in reverse slot order.
// Each cell holds one transaction, so up to SLOTS transactions are in
// flight, and empty cells close up while the output is stalled.
// Layout registers are written through cfg_we/cfg_index/cfg_data; write them
// only while no transaction is in flight. Slot codes 6 and 7 take no bits, a
// slot_count above SLOTS acts as SLOTS, unnamed fields but bank read as zero,
// and the rank width still consumes address bits though rank is not reported.
// ----------------------------------------------------------------------------
module dram_address_field_decoder_core #(
	parameter int SLOTS          = 8,
	parameter int ADDR_BITS      = 32,
	parameter int REQUESTOR_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [adfd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [adfd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	// input stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// tdata: address[31:0], requestor_id[39:32]
	input  logic [adfd_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
	// output stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// tdata: bank_group[31:0], bank[39:32], subarray[71:40], row[103:72],
	//        column[135:104]
	output logic [adfd_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata
);
	import adfd_pkg::*;

	// requestor ID is cut to REQUESTOR_BITS, then to the 8-bit bank field
	localparam logic [BANK_BITS-1:0] RID_MASK = (REQUESTOR_BITS >= BANK_BITS) ?
		{BANK_BITS{1'b1}} : BANK_BITS'((1 << REQUESTOR_BITS) - 1);

	adfd_cfg_t             cfg;

	logic [IN_ADDR_BITS-1:0] in_addr;
	logic [IN_RID_BITS-1:0]  in_rid;

	logic                  chain_valid [SLOTS+1];
	logic                  chain_ready [SLOTS+1];
	logic [ADDR_BITS-1:0]  chain_rest  [SLOTS+1];
	adfd_fields_t          chain_fields[SLOTS+1];

	adfd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign in_addr = s_axis_tdata[IN_ADDR_BITS-1:0];
	assign in_rid  = s_axis_tdata[IN_TDATA_BITS-1:IN_ADDR_BITS];

	// head of the chain: address in ADDR_BITS, all fields zero, bank preset
	generate
		if (ADDR_BITS >= IN_ADDR_BITS) begin : g_addr_ext
			assign chain_rest[0] = {{(ADDR_BITS-IN_ADDR_BITS){1'b0}}, in_addr};
		end else begin : g_addr_cut
			assign chain_rest[0] = in_addr[ADDR_BITS-1:0];
		end
	endgenerate

	always_comb begin
		chain_fields[0]      = '0;
		chain_fields[0].bank = in_rid & RID_MASK;
	end

	assign chain_valid[0] = s_axis_tvalid;
	assign s_axis_tready  = chain_ready[0];

	// cell i serves slot SLOTS-1-i
	generate
		for (genvar i = 0; i < SLOTS; i++) begin : g_cell
			adfd_cell #(
				.ADDR_BITS (ADDR_BITS),
				.SLOT      (SLOTS - 1 - i)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cfg        (cfg),
				.in_valid   (chain_valid[i]),
				.in_ready   (chain_ready[i]),
				.in_rest    (chain_rest[i]),
				.in_fields  (chain_fields[i]),
				.out_valid  (chain_valid[i+1]),
				.out_ready  (chain_ready[i+1]),
				.out_rest   (chain_rest[i+1]),
				.out_fields (chain_fields[i+1])
			);
		end
	endgenerate

	// last cell is the output register
	assign chain_ready[SLOTS] = m_axis_tready;
	assign m_axis_tvalid      = chain_valid[SLOTS];
	assign m_axis_tdata       = chain_fields[SLOTS];

`ifndef SYNTHESIS
	// an empty output cell means every cell can take a transaction
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output cell is empty");

	// input only stalls when the output is stalled with a result
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output backpressure");

	// a result leaving the output frees the head next cycle unless the head took a new transaction
	a_drain_frees_head: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready) |=> s_axis_tready || $past(s_axis_tvalid))
		else $error("chain did not advance after output transaction");
`endif

endmodule
